### sv/tce_pkg.sv
// ----------------------------------------------------------------------------
// tce_pkg: shared definitions for the text console engine
// Screen geometry, field widths, command codes, the decoded operation and the
// queue entry that passes from the front end to the back end, and the back-end states.
// ----------------------------------------------------------------------------
package tce_pkg;

	localparam int SCREEN_COLS = 80;
	localparam int SCREEN_ROWS = 25;
	localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;

	localparam int CMD_W  = 3;
	localparam int BYTE_W = 8;
	localparam int CELL_W = 2 * BYTE_W;
	localparam int COL_W  = $clog2(SCREEN_COLS);
	localparam int ROW_W  = $clog2(SCREEN_ROWS);
	localparam int COLE_W = $clog2(SCREEN_COLS + 1);
	localparam int ROWE_W = $clog2(SCREEN_ROWS + 1);
	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int IDX_W  = ADDR_W + 1;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [CMD_W-1:0] CMD_PUT_CHAR   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_NEWLINE    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_BACKSPACE  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SET_CURSOR = 3'd4;
	localparam logic [CMD_W-1:0] CMD_FILL_RECT  = 3'd5;
	localparam logic [CMD_W-1:0] CMD_READ_CELL  = 3'd6;

	localparam logic [BYTE_W-1:0] BLANK_CHAR = 8'h20;
	localparam logic [BYTE_W-1:0] LINE_FEED  = 8'h0A;
	localparam logic [BYTE_W-1:0] RESET_ATTR = 8'h07;

	typedef enum logic [2:0] {
		OP_PUT,
		OP_NEWLINE,
		OP_BACKSPACE,
		OP_CLEAR,
		OP_SET_CURSOR,
		OP_FILL,
		OP_READ,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [COL_W-1:0]  x;
		logic [ROW_W-1:0]  y;
		logic [COLE_W-1:0] x_end;
		logic [ROWE_W-1:0] y_end;
		logic [BYTE_W-1:0] ch;
	} task_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SWEEP,
		ST_SCROLL,
		ST_BLANK,
		ST_FILL,
		ST_DONE
	} bk_state_t;

endpackage

### sv/tce_if.sv
// ----------------------------------------------------------------------------
// tce_if: command and response channels of the text console engine
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface tce_cmd_if;
	import tce_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [BYTE_W-1:0] col;
	logic [BYTE_W-1:0] row;
	logic [BYTE_W-1:0] fill_width;
	logic [BYTE_W-1:0] fill_height;
	logic [BYTE_W-1:0] character;

	modport source (
		output valid, command, col, row, fill_width, fill_height, character,
		input  ready
	);
	modport sink (
		input  valid, command, col, row, fill_width, fill_height, character,
		output ready
	);
endinterface

interface tce_rsp_if;
	import tce_pkg::*;

	logic              valid;
	logic              ready;
	logic [COL_W-1:0]  cursor_col;
	logic [ROW_W-1:0]  cursor_row;
	logic [ADDR_W-1:0] cursor_linear;
	logic [CELL_W-1:0] cell_value;

	modport source (
		output valid, cursor_col, cursor_row, cursor_linear, cell_value,
		input  ready
	);
	modport sink (
		input  valid, cursor_col, cursor_row, cursor_linear, cell_value,
		output ready
	);
endinterface

### sv/text_console_engine_unit.sv
// ----------------------------------------------------------------------------
// text_console_engine_unit: text console engine, top level
// A simple command is dispatched from the back end's idle state and answered
// from its done state; the back end finishes one command before it pops the
// next. Clear sweeps every cell, a newline on the last row scrolls and then
// blanks the bottom row through the one-write-port cell store, and a fill
// writes width * height cells after clipping.
// After reset a pass blanks the store; no command is taken meanwhile.
// ----------------------------------------------------------------------------
module text_console_engine_unit
	import tce_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	tce_cmd_if.sink           cmd,
	tce_rsp_if.source         rsp,
	input  logic              cfg_we,
	input  logic [BYTE_W-1:0] cfg_wdata
);

	logic  push;
	task_t push_task;
	logic  pop;
	logic  queue_full;
	logic  head_valid;
	task_t head;
	logic  init_busy;

	tce_front u_front (
		.cmd        (cmd),
		.queue_full (queue_full),
		.init_busy  (init_busy),
		.push       (push),
		.push_task  (push_task)
	);

	tce_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_task  (push_task),
		.pop        (pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head       (head)
	);

	tce_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.init_busy  (init_busy),
		.rsp        (rsp)
	);

endmodule

### sv/tce_front.sv
// ----------------------------------------------------------------------------
// tce_front: command decode and clipping
// Accepts command transactions, resolves line feeds, clamps cursor targets,
// clips fill rectangles and drops empty or off-screen fills and reads to no-ops.
// ----------------------------------------------------------------------------
module tce_front
	import tce_pkg::*;
(
	tce_cmd_if.sink cmd,
	input  logic    queue_full,
	input  logic    init_busy,
	output logic    push,
	output task_t   push_task
);

	logic       col_ok;
	logic       row_ok;
	logic [8:0] x_sum;
	logic [8:0] y_sum;

	assign cmd.ready = !queue_full && !init_busy;
	assign push      = cmd.valid && cmd.ready;

	assign col_ok = cmd.col < BYTE_W'(SCREEN_COLS);
	assign row_ok = cmd.row < BYTE_W'(SCREEN_ROWS);
	assign x_sum  = {1'b0, cmd.col} + {1'b0, cmd.fill_width};
	assign y_sum  = {1'b0, cmd.row} + {1'b0, cmd.fill_height};

	always_comb begin
		push_task       = '0;
		push_task.op    = OP_NOP;
		push_task.ch    = cmd.character;
		unique case (cmd.command)
			CMD_PUT_CHAR: begin
				push_task.op = (cmd.character == LINE_FEED) ? OP_NEWLINE : OP_PUT;
			end
			CMD_NEWLINE: begin
				push_task.op = OP_NEWLINE;
			end
			CMD_BACKSPACE: begin
				push_task.op = OP_BACKSPACE;
			end
			CMD_CLEAR: begin
				push_task.op = OP_CLEAR;
			end
			CMD_SET_CURSOR: begin
				push_task.op = OP_SET_CURSOR;
				push_task.x  = col_ok ? COL_W'(cmd.col) : COL_W'(SCREEN_COLS - 1);
				push_task.y  = row_ok ? ROW_W'(cmd.row) : ROW_W'(SCREEN_ROWS - 1);
			end
			CMD_FILL_RECT: begin
				if (col_ok && row_ok && cmd.fill_width != '0 && cmd.fill_height != '0) begin
					push_task.op    = OP_FILL;
					push_task.x     = COL_W'(cmd.col);
					push_task.y     = ROW_W'(cmd.row);
					push_task.x_end = (x_sum < 9'(SCREEN_COLS)) ? COLE_W'(x_sum)
						: COLE_W'(SCREEN_COLS);
					push_task.y_end = (y_sum < 9'(SCREEN_ROWS)) ? ROWE_W'(y_sum)
						: ROWE_W'(SCREEN_ROWS);
				end
			end
			CMD_READ_CELL: begin
				if (col_ok && row_ok) begin
					push_task.op = OP_READ;
					push_task.x  = COL_W'(cmd.col);
					push_task.y  = ROW_W'(cmd.row);
				end
			end
			default: begin
				push_task.op = OP_NOP;
			end
		endcase
	end

endmodule

### sv/tce_queue.sv
// ----------------------------------------------------------------------------
// tce_queue: command queue between front and back end
// Small FIFO of decoded commands so that either side can stall on its own.
// ----------------------------------------------------------------------------
module tce_queue
	import tce_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  task_t push_task,
	input  logic  pop,
	output logic  full,
	output logic  head_valid,
	output task_t head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	task_t            slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = count_q == CNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_task;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### sv/tce_back.sv
// ----------------------------------------------------------------------------
// tce_back: command execution
// Holds the cell store, cursor and attribute; runs writes, scroll, clear and
// fill sweeps one cell per cycle and registers the response.
// ----------------------------------------------------------------------------
module tce_back
	import tce_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [BYTE_W-1:0] cfg_wdata,
	input  logic              head_valid,
	input  task_t             head,
	output logic              pop,
	output logic              init_busy,
	tce_rsp_if.source         rsp
);

	function automatic logic [ADDR_W-1:0] lin_addr(
		input logic [ROW_W-1:0] r,
		input logic [COL_W-1:0] c
	);
		return ADDR_W'(ADDR_W'(r) * ADDR_W'(SCREEN_COLS)) + ADDR_W'(c);
	endfunction

	logic [CELL_W-1:0] mem [CELL_COUNT];

	bk_state_t         state_q;
	bk_state_t         state_d;
	logic [IDX_W-1:0]  idx_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic [BYTE_W-1:0] attr_q;
	task_t             job_q;
	logic [COL_W-1:0]  fx_q;
	logic [ROW_W-1:0]  fy_q;
	logic              rd_q;
	logic              copy_v_s1;
	logic [ADDR_W-1:0] copy_addr_s1;
	logic [CELL_W-1:0] rdata_s1;

	logic              out_v_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [ADDR_W-1:0] out_lin_q;
	logic [CELL_W-1:0] out_cell_q;

	logic [ADDR_W-1:0] cur_lin;
	logic [ADDR_W-1:0] head_lin;
	logic [ADDR_W-1:0] fill_lin;
	logic [CELL_W-1:0] blank_cell;
	logic              last_col;
	logic              last_row;
	logic              idx_last;
	logic              idx_end;
	logic              fx_end;
	logic              fy_end;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic              load_out;

	assign cur_lin    = lin_addr(cur_row_q, cur_col_q);
	assign head_lin   = lin_addr(head.y, head.x);
	assign fill_lin   = lin_addr(fy_q, fx_q);
	assign blank_cell = {attr_q, BLANK_CHAR};
	assign last_col   = cur_col_q == COL_W'(SCREEN_COLS - 1);
	assign last_row   = cur_row_q == ROW_W'(SCREEN_ROWS - 1);
	assign idx_last   = idx_q == IDX_W'(CELL_COUNT - 1);
	assign idx_end    = idx_q == IDX_W'(CELL_COUNT);
	assign fx_end     = (COLE_W'(fx_q) + COLE_W'(1)) == job_q.x_end;
	assign fy_end     = (ROWE_W'(fy_q) + ROWE_W'(1)) == job_q.y_end;
	assign init_busy  = state_q == ST_INIT;

	assign rsp.valid         = out_v_q;
	assign rsp.cursor_col    = out_col_q;
	assign rsp.cursor_row    = out_row_q;
	assign rsp.cursor_linear = out_lin_q;
	assign rsp.cell_value    = out_cell_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (idx_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (head_valid) begin
					unique case (head.op)
						OP_PUT:     state_d = (last_col && last_row) ? ST_SCROLL : ST_DONE;
						OP_NEWLINE: state_d = last_row ? ST_SCROLL : ST_DONE;
						OP_CLEAR:   state_d = ST_SWEEP;
						OP_FILL:    state_d = ST_FILL;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_SWEEP: begin
				if (idx_last) state_d = ST_DONE;
			end
			ST_SCROLL: begin
				if (idx_end) state_d = ST_BLANK;
			end
			ST_BLANK: begin
				if (idx_last) state_d = ST_DONE;
			end
			ST_FILL: begin
				if (fx_end && fy_end) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_v_q || rsp.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[ADDR_W-1:0];
		mem_wdata = blank_cell;
		mem_re    = 1'b0;
		mem_raddr = idx_q[ADDR_W-1:0];
		pop       = 1'b0;
		load_out  = 1'b0;
		unique case (state_q) inside
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = {RESET_ATTR, BLANK_CHAR};
			end
			ST_IDLE: begin
				pop = head_valid;
				if (head_valid) begin
					case (head.op)
						OP_PUT: begin
							mem_we    = 1'b1;
							mem_waddr = cur_lin;
							mem_wdata = {attr_q, head.ch};
						end
						OP_BACKSPACE: begin
							mem_we    = cur_col_q != '0;
							mem_waddr = cur_lin - ADDR_W'(1);
						end
						OP_READ: begin
							mem_re    = 1'b1;
							mem_raddr = head_lin;
						end
						default: begin
							mem_we = 1'b0;
						end
					endcase
				end
			end
			ST_SWEEP, ST_BLANK: begin
				mem_we = 1'b1;
			end
			ST_SCROLL: begin
				mem_re    = !idx_end;
				mem_we    = copy_v_s1;
				mem_waddr = copy_addr_s1;
				mem_wdata = rdata_s1;
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = fill_lin;
				mem_wdata = {attr_q, job_q.ch};
			end
			ST_DONE: begin
				load_out = !out_v_q || rsp.ready;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_s1 <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		copy_addr_s1 <= idx_q[ADDR_W-1:0] - ADDR_W'(SCREEN_COLS);
		if (pop) begin
			job_q <= head;
		end
		if (load_out) begin
			out_col_q  <= cur_col_q;
			out_row_q  <= cur_row_q;
			out_lin_q  <= cur_lin;
			out_cell_q <= rd_q ? rdata_s1 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			idx_q     <= '0;
			cur_col_q <= '0;
			cur_row_q <= '0;
			attr_q    <= RESET_ATTR;
			fx_q      <= '0;
			fy_q      <= '0;
			rd_q      <= 1'b0;
			copy_v_s1 <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			copy_v_s1 <= (state_q == ST_SCROLL) && !idx_end;

			if (cfg_we) begin
				attr_q <= cfg_wdata;
			end

			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end

			unique case (state_q) inside
				ST_INIT, ST_SWEEP, ST_BLANK: begin
					idx_q <= idx_q + 1'b1;
				end
				ST_SCROLL: begin
					idx_q <= idx_end ? IDX_W'(CELL_COUNT - SCREEN_COLS) : idx_q + 1'b1;
				end
				ST_IDLE: begin
					idx_q <= (head.op == OP_CLEAR) ? '0 : IDX_W'(SCREEN_COLS);
				end
				ST_FILL: begin
					if (fx_end) begin
						fx_q <= job_q.x;
						fy_q <= fy_q + 1'b1;
					end else begin
						fx_q <= fx_q + 1'b1;
					end
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase

			if (pop) begin
				rd_q <= head.op == OP_READ;
				fx_q <= head.x;
				fy_q <= head.y;
				case (head.op)
					OP_PUT: begin
						if (last_col) begin
							cur_col_q <= '0;
							if (!last_row) cur_row_q <= cur_row_q + 1'b1;
						end else begin
							cur_col_q <= cur_col_q + 1'b1;
						end
					end
					OP_NEWLINE: begin
						cur_col_q <= '0;
						if (!last_row) cur_row_q <= cur_row_q + 1'b1;
					end
					OP_BACKSPACE: begin
						if (cur_col_q != '0) cur_col_q <= cur_col_q - 1'b1;
					end
					OP_CLEAR: begin
						cur_col_q <= '0;
						cur_row_q <= '0;
					end
					OP_SET_CURSOR: begin
						cur_col_q <= head.x;
						cur_row_q <= head.y;
					end
					default: begin
						cur_col_q <= cur_col_q;
					end
				endcase
			end
		end
	end

endmodule
